// ===== sv/fmvsk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmvsk_pkg
// Types, constants and table functions shared by the key-on voice filter.
// ----------------------------------------------------------------------------
package fmvsk_pkg;

  localparam int CHANNELS = 9;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [7:0] KEY_BIT   = 8'h20;
  localparam logic [7:0] CH_REG_LO = 8'hb0;
  localparam logic [7:0] CH_REG_HI = 8'hb8;
  localparam logic [7:0] LVL_MASK  = 8'hc0;
  localparam logic [7:0] VOICE_REG = 8'hc0;

  // Hash byte sequence: five modulator bytes, five carrier bytes, voice byte.
  localparam logic [3:0] HASH_LAST = 4'd10;
  localparam logic [3:0] LVL_STEP  = 4'd6;

  localparam logic REG_FP_COUNT = 1'b0;

  typedef struct packed {
    logic        kind;
    logic [7:0]  reg_index;
    logic [7:0]  write_value;
    logic [5:0]  slot;
    logic [31:0] fingerprint;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_index;
    logic [7:0] out_value;
    logic       muted;
  } out_item_t;

  typedef struct packed {
    logic init;
    logic step;
    logic lvl_mask;
  } hash_ctl_t;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_LOAD  = 1'b1;

  function automatic logic [7:0] op_base(input logic [3:0] ch);
    logic [7:0] b;
    case (ch)
      4'd0:    b = 8'h00;
      4'd1:    b = 8'h01;
      4'd2:    b = 8'h02;
      4'd3:    b = 8'h08;
      4'd4:    b = 8'h09;
      4'd5:    b = 8'h0a;
      4'd6:    b = 8'h10;
      4'd7:    b = 8'h11;
      4'd8:    b = 8'h12;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] timbre_base(input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = 8'h20;
      3'd1:    b = 8'h40;
      3'd2:    b = 8'h60;
      3'd3:    b = 8'h80;
      3'd4:    b = 8'he0;
      default: b = 8'h20;
    endcase
    return b;
  endfunction

  // Shadow address of hash byte k for channel ch.
  function automatic logic [7:0] hash_addr(input logic [3:0] ch, input logic [3:0] k);
    logic [7:0] m;
    logic [7:0] a;
    logic [3:0] kc;
    m  = op_base(ch);
    kc = k - 4'd5;
    if (k < 4'd5) begin
      a = timbre_base(k[2:0]) + m;
    end else if (k < HASH_LAST) begin
      a = timbre_base(kc[2:0]) + m + 8'd3;
    end else begin
      a = VOICE_REG + {4'b0, ch};
    end
    return a;
  endfunction

endpackage

// ===== sv/fmvsk_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmvsk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fmvsk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/fmvsk_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmvsk_hash
// FNV-1a accumulator: one byte folded in per step, one multiply per cycle while ctl.step is high.
// ----------------------------------------------------------------------------
module fmvsk_hash (
  input  logic                clk,
  input  fmvsk_pkg::hash_ctl_t ctl,
  input  logic [7:0]          data,
  output logic [31:0]         hash
);
  import fmvsk_pkg::*;

  logic [31:0] hash_r;
  logic [31:0] hash_nxt;
  logic [7:0]  byte_in;
  logic [31:0] mixed;
  logic [31:0] prod;

  // The carrier level byte only contributes its scaling bits.
  assign byte_in = ctl.lvl_mask ? (data & LVL_MASK) : data;
  assign mixed   = hash_r ^ {24'b0, byte_in};
  assign prod    = mixed * FNV_PRIME;

  always_comb begin
    hash_nxt = hash_r;
    if (ctl.init) begin
      hash_nxt = FNV_BASIS;
    end else if (ctl.step) begin
      hash_nxt = prod;
    end
  end

  always_ff @(posedge clk) begin
    hash_r <= hash_nxt;
  end

  assign hash = hash_r;

endmodule

// ===== sv/fm_voice_solo_keyon_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fm_voice_solo_keyon_filter
// Register-write filter for a 9-channel FM synth: shadows every register,
// hashes a channel's timbre on key-on and mutes voices not in the list.
// ----------------------------------------------------------------------------
// Flow: a fingerprint load is written to the table on acceptance; a plain write
// passes through ST_EMIT to the output register; a key-on write first runs 11
// shadow read/multiply pairs, then scans the list with one memory read and
// compare per entry until a match or the last active entry.
// One word is in flight at a time; the output register lets the next word in.
// Reset: after rst_n rises, a sweep over all 256 addresses clears the shadow memory with in_stall high.
module fm_voice_solo_keyon_filter #(
  parameter int MAX_FINGERPRINTS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fmvsk_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fmvsk_pkg::out_item_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import fmvsk_pkg::*;

  localparam int FA_W = (MAX_FINGERPRINTS > 1) ? $clog2(MAX_FINGERPRINTS) : 1;
  localparam logic [8:0] MAX_FP = 9'(MAX_FINGERPRINTS);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_HREAD = 7'b0000100,
    ST_HMUL  = 7'b0001000,
    ST_SREAD = 7'b0010000,
    ST_SCMP  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [7:0]  clr_cnt_r, clr_cnt_nxt;
  logic [6:0]  fp_count_r, fp_count_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [8:0]  idx_r, idx_nxt;
  logic [8:0]  lim_r, lim_nxt;
  logic        found_r, found_nxt;
  logic [7:0]  p_reg_r, p_reg_nxt;
  logic [7:0]  p_val_r, p_val_nxt;
  logic [3:0]  p_ch_r, p_ch_nxt;
  logic        p_filt_r, p_filt_nxt;
  logic        p_edge_r, p_edge_nxt;
  logic [CHANNELS-1:0] muted_r, muted_nxt;
  logic [CHANNELS-1:0] prev_key_r, prev_key_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic        accept;
  logic        cfg_we;
  logic [7:0]  in_ch8;
  logic        in_filt;
  logic        in_key;
  logic [8:0]  cnt9;
  logic [8:0]  slot9;
  logic        out_free;
  logic        key_now;
  logic        mute_now;

  logic        sh_we;
  logic [7:0]  sh_waddr;
  logic [7:0]  sh_wdata;
  logic [7:0]  sh_raddr;
  logic [7:0]  sh_rdata;
  logic        fp_we;
  logic [FA_W-1:0] fp_waddr;
  logic [FA_W-1:0] fp_raddr;
  logic [31:0] fp_rdata;
  hash_ctl_t   hctl;
  logic [31:0] hash;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_FP_COUNT);
  assign prdata = (paddr[2] == REG_FP_COUNT) ? {25'b0, fp_count_r} : 32'b0;

  assign in_ch8  = in_data.reg_index - CH_REG_LO;
  assign in_filt = (fp_count_r != 7'd0) && (in_data.reg_index >= CH_REG_LO) &&
                   (in_data.reg_index <= CH_REG_HI);
  assign in_key  = (in_data.write_value & KEY_BIT) != 8'd0;
  assign cnt9    = {2'b0, fp_count_r};
  assign slot9   = {3'b0, in_data.slot};

  // Shadow memory: cleared by a sweep after reset, then written on each accepted register write.
  always_comb begin
    sh_we    = 1'b0;
    sh_waddr = in_data.reg_index;
    sh_wdata = in_data.write_value;
    if (state_r == ST_CLEAR) begin
      sh_we    = 1'b1;
      sh_waddr = clr_cnt_r;
      sh_wdata = 8'd0;
    end else if (accept && in_data.kind == KIND_WRITE) begin
      sh_we = 1'b1;
    end
  end

  assign sh_raddr = hash_addr(p_ch_r, k_r);
  assign fp_we    = accept && (in_data.kind == KIND_LOAD) && (slot9 < MAX_FP);
  assign fp_waddr = slot9[FA_W-1:0];
  assign fp_raddr = idx_r[FA_W-1:0];

  fmvsk_ram #(.WIDTH(8), .DEPTH(256)) u_shadow (
    .clk   (clk),
    .we    (sh_we),
    .waddr (sh_waddr),
    .wdata (sh_wdata),
    .raddr (sh_raddr),
    .rdata (sh_rdata)
  );

  fmvsk_ram #(.WIDTH(32), .DEPTH(MAX_FINGERPRINTS)) u_fp_table (
    .clk   (clk),
    .we    (fp_we),
    .waddr (fp_waddr),
    .wdata (in_data.fingerprint),
    .raddr (fp_raddr),
    .rdata (fp_rdata)
  );

  fmvsk_hash u_hash (
    .clk  (clk),
    .ctl  (hctl),
    .data (sh_rdata),
    .hash (hash)
  );

  // Mute decision for the channel write being finished.
  assign key_now  = (p_val_r & KEY_BIT) != 8'd0;
  always_comb begin
    mute_now = p_edge_r ? !found_r : muted_r[p_ch_r];
    if (!key_now) begin
      mute_now = 1'b0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    fp_count_nxt  = fp_count_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    lim_nxt       = lim_r;
    found_nxt     = found_r;
    p_reg_nxt     = p_reg_r;
    p_val_nxt     = p_val_r;
    p_ch_nxt      = p_ch_r;
    p_filt_nxt    = p_filt_r;
    p_edge_nxt    = p_edge_r;
    muted_nxt     = muted_r;
    prev_key_nxt  = prev_key_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    hctl          = '0;

    if (cfg_we) begin
      fp_count_nxt = pwdata[6:0];
    end

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 8'd1;
        if (clr_cnt_r == 8'hff) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && in_data.kind == KIND_WRITE) begin
          p_reg_nxt  = in_data.reg_index;
          p_val_nxt  = in_data.write_value;
          p_ch_nxt   = in_ch8[3:0];
          p_filt_nxt = in_filt;
          p_edge_nxt = in_filt && in_key && !prev_key_r[in_ch8[3:0]];
          k_nxt      = 4'd0;
          idx_nxt    = 9'd0;
          lim_nxt    = (cnt9 > MAX_FP) ? MAX_FP : cnt9;
          if (in_filt && in_key && !prev_key_r[in_ch8[3:0]]) begin
            hctl.init = 1'b1;
            state_nxt = ST_HREAD;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_HREAD: begin
        state_nxt = ST_HMUL;
      end
      ST_HMUL: begin
        hctl.step     = 1'b1;
        hctl.lvl_mask = (k_r == LVL_STEP);
        k_nxt         = k_r + 4'd1;
        state_nxt     = (k_r == HASH_LAST) ? ST_SREAD : ST_HREAD;
      end
      ST_SREAD: begin
        state_nxt = ST_SCMP;
      end
      ST_SCMP: begin
        idx_nxt = idx_r + 9'd1;
        if (fp_rdata == hash) begin
          found_nxt = 1'b1;
          state_nxt = ST_EMIT;
        end else if (idx_r + 9'd1 == lim_r) begin
          found_nxt = 1'b0;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_SREAD;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.out_index = p_reg_r;
          out_data_nxt.out_value = p_val_r;
          out_data_nxt.muted     = 1'b0;
          if (p_filt_r) begin
            muted_nxt[p_ch_r]    = mute_now;
            prev_key_nxt[p_ch_r] = key_now;
            out_data_nxt.muted   = mute_now;
            if (mute_now) begin
              out_data_nxt.out_value = p_val_r & ~KEY_BIT;
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= 8'd0;
      fp_count_r  <= 7'd0;
      muted_r     <= '0;
      prev_key_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      fp_count_r  <= fp_count_nxt;
      muted_r     <= muted_nxt;
      prev_key_r  <= prev_key_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    idx_r      <= idx_nxt;
    lim_r      <= lim_nxt;
    found_r    <= found_nxt;
    p_reg_r    <= p_reg_nxt;
    p_val_r    <= p_val_nxt;
    p_ch_r     <= p_ch_nxt;
    p_filt_r   <= p_filt_nxt;
    p_edge_r   <= p_edge_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/fmvsk_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmvsk_chk
// Port-level checks for the key-on voice filter, bound to the top level.
// ----------------------------------------------------------------------------
module fmvsk_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input fmvsk_pkg::out_item_t out_data
);
  import fmvsk_pkg::*;

  // A stalled word holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed or vanished");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // The shadow clear sweep keeps the input closed right after reset.
  a_reset_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open during shadow clear");

  a_muted_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.muted |-> (out_data.out_value & KEY_BIT) == 8'd0)
    else $error("muted word still carries key-on");

  a_muted_reg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.muted |->
      out_data.out_index >= CH_REG_LO && out_data.out_index <= CH_REG_HI)
    else $error("muted word outside channel key registers");

endmodule

bind fm_voice_solo_keyon_filter fmvsk_chk u_fmvsk_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
